>>> rtl/sha256_stream_hasher_assert.svh
// assertion macros for the sha256 stream hasher
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, clk, rst_n, cond, seq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (seq)) \
    else $error("label failed");
`define SHA_ASSERT_NEXT(label, clk, rst_n, cond, seq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (seq)) \
    else $error("label failed");
`else
`define SHA_ASSERT_IMPL(label, clk, rst_n, cond, seq)
`define SHA_ASSERT_NEXT(label, clk, rst_n, cond, seq)
`endif
`endif

>>> rtl/sha256_pkg.sv
package sha256_pkg;

  localparam int BlockBytes = 64;
  localparam int WinDepth = 16;
  localparam int WinAw = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_PAD,
    ST_LEN,
    ST_INIT,
    ST_RD,
    ST_RND,
    ST_FIN,
    ST_OUT
  } sha_state_t;

  // schedule memory write request
  typedef struct packed {
    logic              en;
    logic [WinAw-1:0]  addr;
    logic [31:0]       data;
  } win_wr_t;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] v);
    big_s0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] v);
    big_s1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] v);
    small_s0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] v);
    small_s1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    case (i)
      3'd0: init_hash = 32'h6a09e667;
      3'd1: init_hash = 32'hbb67ae85;
      3'd2: init_hash = 32'h3c6ef372;
      3'd3: init_hash = 32'ha54ff53a;
      3'd4: init_hash = 32'h510e527f;
      3'd5: init_hash = 32'h9b05688c;
      3'd6: init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

>>> rtl/sha256_win_mem.sv
module sha256_win_mem #(
  parameter int Depth = sha256_pkg::WinDepth
) (
  input  logic                     clk,
  input  sha256_pkg::win_wr_t      wr,
  input  logic [$clog2(Depth)-1:0] rd_addr_a,
  input  logic [$clog2(Depth)-1:0] rd_addr_b,
  output logic [31:0]              rd_data_a,
  output logic [31:0]              rd_data_b
);
  import sha256_pkg::*;

  logic [31:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[$clog2(Depth)-1:0]] <= wr.data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end
endmodule

>>> rtl/sha256_stream_hasher.sv
// channel  | direction | payload
// in_      | slave     | tdata[7:0] message_byte, tuser[0] byte_valid, tlast end_of_message
// out_     | master    | tdata[31:0] digest_word, tuser[2:0] word_index, tlast last_word
//
// a data byte is accepted in idle, then read-merged-written into its schedule word
// a full block adds init, 16 rounds (read, re-read, round),
//   48 rounds (two read pairs, schedule sum, schedule write, round), then the chaining add
// padding writes each byte through pad then write, then 8 digest words, one per accepted out word
// synchronous active-low reset restores the initial hash and clears the length
// in_tready stays low while a block compresses or the digest drains
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] message_byte
  input  logic        in_tuser,   // [0] byte_valid
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast
);
  import sha256_pkg::*;
  `include "sha256_stream_hasher_assert.svh"

  sha_state_t state_r, state_nxt;

  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [63:0] len_r;
  logic [5:0]  pos_r;
  logic [7:0]  byte_r;
  logic        last_r;      // padding pending after current byte
  logic [3:0]  padcnt_r;    // 0 = 0x80 byte, 1 = zero bytes until inlen_r selects the length bytes
  logic        inlen_r;     // in length phase
  logic [2:0]  lenidx_r;
  logic [5:0]  t_r;
  logic [1:0]  ph_r;
  logic [31:0] wa_r, wb_r;
  logic [2:0]  oidx_r;

  win_wr_t     wr;
  logic [3:0]  ra, rb;
  logic [31:0] rda, rdb;

  sha256_win_mem #(.Depth(WinDepth)) u_mem (
    .clk(clk), .wr(wr), .rd_addr_a(ra), .rd_addr_b(rb),
    .rd_data_a(rda), .rd_data_b(rdb)
  );

  // byte write path: read the word, merge byte, write back
  logic [1:0]  bsel;
  logic [31:0] merged;
  assign bsel = pos_r[1:0];
  always_comb begin
    merged = (bsel == 2'd0) ? 32'd0 : rda;
    case (bsel)
      2'd0: merged[31:24] = byte_r;
      2'd1: merged[23:16] = byte_r;
      2'd2: merged[15:8] = byte_r;
      default: merged[7:0] = byte_r;
    endcase
  end

  // round datapath
  logic [31:0] wt, t1, t2, sched;
  logic [31:0] wt_r;
  assign sched = small_s1(wa_r) + wb_r + small_s0(rda) + rdb;
  assign wt = (t_r < 6'd16) ? rda : wt_r;
  assign t1 = v_r[7] + big_s1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + RoundK[t_r] + wt;
  assign t2 = big_s0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) state_nxt = ST_WRITE;
          else if (in_tlast) state_nxt = ST_PAD;
        end
      end
      ST_WRITE: begin
        if (pos_r == 6'd63) state_nxt = ST_INIT;
        else if (last_r) state_nxt = ST_PAD;
        else state_nxt = ST_IDLE;
      end
      ST_PAD: state_nxt = ST_WRITE;
      ST_INIT: state_nxt = ST_RD;
      ST_RD: state_nxt = ST_RND;
      ST_RND: begin
        if (ph_r == 2'd3 || (t_r < 6'd16 && ph_r == 2'd1)) begin
          if (t_r == 6'd63) state_nxt = ST_FIN;
          else state_nxt = ST_RD;
        end
      end
      ST_FIN: begin
        if (last_r) state_nxt = ST_PAD;
        else state_nxt = ST_IDLE;
      end
      ST_OUT: begin
        if (out_tready && oidx_r == 3'd7) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_FIN && last_r && inlen_r && lenidx_r == 3'd0 && pos_r == 6'd0)
      state_nxt = ST_OUT;
  end

  // outputs and memory control
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_OUT);
    out_tdata = h_r[oidx_r];
    out_tuser = oidx_r;
    out_tlast = (oidx_r == 3'd7);
    ra = pos_r[5:2];
    rb = 4'd0;
    wr = '0;
    case (state_r)
      ST_WRITE: begin
        wr.en = 1'b1;
        wr.addr = pos_r[5:2];
        wr.data = merged;
      end
      ST_RD: begin
        if (t_r < 6'd16) ra = t_r[3:0];
        else begin
          ra = t_r[3:0] - 4'd2;
          rb = t_r[3:0] - 4'd7;
        end
      end
      ST_RND: begin
        if (ph_r == 2'd0) begin
          if (t_r >= 6'd16) begin
            ra = t_r[3:0] - 4'd15;
            rb = t_r[3:0];
          end else begin
            ra = t_r[3:0];
          end
        end
        if (ph_r == 2'd2) begin
          wr.en = 1'b1;
          wr.addr = t_r[3:0];
          wr.data = wt_r;
        end
      end
      default: ;
    endcase
  end

  // padding byte selection
  logic [7:0] padbyte;
  always_comb begin
    if (!inlen_r) padbyte = (padcnt_r == 4'd0) ? 8'h80 : 8'h00;
    else padbyte = len_r[8*(7-lenidx_r) +: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r <= '0;
      pos_r <= '0;
      last_r <= 1'b0;
      inlen_r <= 1'b0;
      padcnt_r <= '0;
      lenidx_r <= '0;
      oidx_r <= '0;
      t_r <= '0;
      ph_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_hash(3'(i));
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            byte_r <= in_tdata;
            last_r <= in_tlast;
            padcnt_r <= '0;
            inlen_r <= 1'b0;
            lenidx_r <= '0;
            if (in_tuser) len_r <= len_r + 64'd8;
          end
        end
        ST_WRITE: begin
          pos_r <= pos_r + 6'd1;
          // eight length bytes wrap lenidx back to zero at the block end
          if (last_r && inlen_r) lenidx_r <= lenidx_r + 3'd1;
        end
        ST_PAD: begin
          if (!inlen_r && padcnt_r != 4'd0 && pos_r == 6'd56) begin
            inlen_r <= 1'b1;
            byte_r <= len_r[63:56];
          end else begin
            byte_r <= padbyte;
          end
          if (!inlen_r && padcnt_r == 4'd0) padcnt_r <= 4'd1;
        end
        ST_INIT: begin
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          t_r <= '0;
          ph_r <= '0;
        end
        ST_RND: begin
          if (ph_r == 2'd0) begin
            wa_r <= rda;
            wb_r <= rdb;
          end
          if (ph_r == 2'd1) wt_r <= sched;
          if (ph_r == 2'd3 || (t_r < 6'd16 && ph_r == 2'd1)) begin
            v_r[7] <= v_r[6];
            v_r[6] <= v_r[5];
            v_r[5] <= v_r[4];
            v_r[4] <= v_r[3] + t1;
            v_r[3] <= v_r[2];
            v_r[2] <= v_r[1];
            v_r[1] <= v_r[0];
            v_r[0] <= t1 + t2;
            t_r <= t_r + 6'd1;
            ph_r <= '0;
          end else begin
            ph_r <= ph_r + 2'd1;
          end
        end
        ST_FIN: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
        end
        ST_OUT: begin
          if (out_tready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= init_hash(3'(i));
              len_r <= '0;
              pos_r <= '0;
              last_r <= 1'b0;
              inlen_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // rounds below 16 read w[t] in ST_RD and again in phase 0; phase 1 uses it from rda

  `SHA_ASSERT_IMPL(a_no_in_busy, clk, rst_n, state_r != ST_IDLE, !in_tready)
  `SHA_ASSERT_IMPL(a_out_only_drain, clk, rst_n, out_tvalid, state_r == ST_OUT)
  `SHA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, $stable(oidx_r))
  `SHA_ASSERT_IMPL(a_round_range, clk, rst_n, state_r == ST_RND, ph_r <= 2'd3)
endmodule
